### src/multilevel_priority_queue_defines.svh
// Assertion macros used by the checker file of the priority queue.
`ifndef MULTILEVEL_PRIORITY_QUEUE_DEFINES_SVH
`define MULTILEVEL_PRIORITY_QUEUE_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define MLPQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define MLPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mlpq_pkg.sv
package mlpq_pkg;

    localparam int LEVELS_DEFAULT = 8;
    localparam int DEPTH_DEFAULT  = 16;

    localparam int VALUE_W     = 32;
    localparam int LEVEL_W     = 3;
    localparam int STATUS_W    = 3;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED = 3'd0,
        ST_FULL   = 3'd1,
        ST_POPPED = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_BADLVL = 3'd4
    } status_t;

endpackage

### src/multilevel_priority_queue.sv
// Multi-level priority queue: one circular FIFO per level in a shared word memory.
// A push or a refused pop passes through S_EXEC into the output registers; a pop that
// returns a word then also passes S_READ, after the registered memory read.
// One item is handled at a time: a new one is taken only in S_IDLE.
// Reset empties every level and clears the pointers; the word memory keeps no reset.
module multilevel_priority_queue #(
    parameter int LEVELS = mlpq_pkg::LEVELS_DEFAULT,
    parameter int DEPTH  = mlpq_pkg::DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // value [31:0], level [34:32], zero [39:35]
    input  logic [mlpq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // cmd
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_value [31:0], out_level [34:32], zero [39:35]
    output logic [mlpq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // status
    output logic [mlpq_pkg::STATUS_W-1:0]       m_axis_tuser
);
    import mlpq_pkg::*;

    localparam int LVL_IDX_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WORDS     = LEVELS * DEPTH;
    localparam int ADDR_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_READ = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic                 cmd_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic [LEVEL_W-1:0]   level_reg;

    logic [PTR_W-1:0]     head_reg [LEVELS];
    logic [PTR_W-1:0]     tail_reg [LEVELS];
    logic [LEVELS-1:0]    nonempty_reg;

    logic [VALUE_W-1:0]   mem [WORDS];
    logic [VALUE_W-1:0]   rd_data_reg;

    logic                 out_valid_reg;
    status_t              out_status_reg;
    logic [VALUE_W-1:0]   out_value_reg;
    logic [LEVEL_W-1:0]   out_level_reg;

    logic                 in_accept;
    logic                 out_free;
    logic                 bad_level;
    logic                 pop_found;
    logic [LVL_IDX_W-1:0] pop_idx;
    logic [LVL_IDX_W-1:0] sel_idx;
    logic [PTR_W-1:0]     sel_head;
    logic [PTR_W-1:0]     sel_tail;
    logic                 sel_ne;
    logic [PTR_W-1:0]     tail_inc;
    logic [PTR_W-1:0]     head_inc;
    logic                 push_full;
    logic [PTR_W-1:0]     slot;
    logic [ADDR_W-1:0]    mem_addr;
    logic                 exec_go;
    logic                 do_push;
    logic                 do_pop;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        pop_found = 1'b0;
        pop_idx   = '0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (nonempty_reg[i])
            begin
                pop_found = 1'b1;
                pop_idx   = LVL_IDX_W'(i);
            end
        end
    end

    assign bad_level = (32'(level_reg) >= 32'(LEVELS));
    assign sel_idx   = cmd_reg ? pop_idx : LVL_IDX_W'(level_reg);
    assign sel_head  = head_reg[sel_idx];
    assign sel_tail  = tail_reg[sel_idx];
    assign sel_ne    = nonempty_reg[sel_idx];
    assign tail_inc  = (sel_tail == PTR_LAST) ? '0 : sel_tail + 1'b1;
    assign head_inc  = (sel_head == PTR_LAST) ? '0 : sel_head + 1'b1;
    assign push_full = sel_ne && (tail_inc == sel_head);
    assign slot      = cmd_reg ? sel_head : (sel_ne ? tail_inc : '0);
    assign mem_addr  = ADDR_W'(sel_idx) * ADDR_W'(DEPTH) + ADDR_W'(slot);

    assign exec_go = (state_reg == S_EXEC) && out_free;
    assign do_push = exec_go && !cmd_reg && !bad_level && !push_full;
    assign do_pop  = exec_go && cmd_reg && pop_found;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = (cmd_reg && pop_found) ? S_READ : S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg   <= s_axis_tuser;
            value_reg <= s_axis_tdata[VALUE_W-1:0];
            level_reg <= s_axis_tdata[VALUE_W +: LEVEL_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonempty_reg <= '0;
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else if (do_push)
        begin
            if (!sel_ne)
            begin
                head_reg[sel_idx]     <= '0;
                tail_reg[sel_idx]     <= '0;
                nonempty_reg[sel_idx] <= 1'b1;
            end
            else
            begin
                tail_reg[sel_idx] <= tail_inc;
            end
        end
        else if (do_pop)
        begin
            if (sel_head == sel_tail)
            begin
                head_reg[sel_idx]     <= '0;
                tail_reg[sel_idx]     <= '0;
                nonempty_reg[sel_idx] <= 1'b0;
            end
            else
            begin
                head_reg[sel_idx] <= head_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[mem_addr] <= value_reg;
        end
        if (do_pop)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec_go && !do_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (state_reg == S_READ)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            out_value_reg <= '0;
            out_level_reg <= '0;
            if (!cmd_reg)
            begin
                if (bad_level)
                begin
                    out_status_reg <= ST_BADLVL;
                end
                else if (push_full)
                begin
                    out_status_reg <= ST_FULL;
                end
                else
                begin
                    out_status_reg <= ST_PUSHED;
                end
            end
            else if (pop_found)
            begin
                out_status_reg <= ST_POPPED;
                out_level_reg  <= LEVEL_W'(pop_idx);
            end
            else
            begin
                out_status_reg <= ST_EMPTY;
            end
        end
        else if (state_reg == S_READ)
        begin
            out_value_reg <= rd_data_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - VALUE_W - LEVEL_W)'(0), out_level_reg, out_value_reg};

endmodule

### src/mlpq_checker.sv
`include "multilevel_priority_queue_defines.svh"

module mlpq_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [mlpq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [mlpq_pkg::STATUS_W-1:0]    m_axis_tuser
);
    import mlpq_pkg::*;

    logic                              out_stall;
    logic                              out_plain;
    logic [OUT_TDATA_W+STATUS_W-1:0]   out_word;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_plain = m_axis_tvalid && (m_axis_tuser != ST_POPPED);
    assign out_word  = {m_axis_tuser, m_axis_tdata};

    `MLPQ_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word), "held item changed")

    `MLPQ_ASSERT_IMP(a_zero_payload, out_plain, m_axis_tdata == '0, "non-pop item carries data")

    `MLPQ_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input overrun")

    `MLPQ_ASSERT_IMP(a_status_range, m_axis_tvalid, m_axis_tuser <= ST_BADLVL, "status out of range")

endmodule

bind multilevel_priority_queue mlpq_checker u_mlpq_checker (.*);
